// File: rtl/core/bdv_pkg.sv
// ----------------------------------------------------------------------------
// bdv_pkg
// Shared types and constants for the box distance voxelizer.
// ----------------------------------------------------------------------------
package bdv_pkg;

  localparam int unsigned REG_W     = 20;  // bound register width
  localparam int unsigned IDX_W     = 10;  // voxel index field width
  localparam int unsigned VALUE_W   = 8;   // result field width
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_DATA_W = 32;
  localparam int unsigned NUM_AXES  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MAX_X = 3'd1,
    REG_BOX_MIN_Y = 3'd2,
    REG_BOX_MAX_Y = 3'd3,
    REG_BOX_MIN_Z = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } bdv_reg_e;

  // Sideband that travels alongside the root datapath
  typedef struct packed {
    logic valid;
    logic all_pos;
    logic sat;
  } bdv_side_t;

  // Signed width of one axis distance
  function automatic int unsigned dist_w(int unsigned coord_bits, int unsigned frac_bits);
    int unsigned cb;
    int unsigned pw;
    cb = (coord_bits < IDX_W) ? coord_bits : IDX_W;
    pw = cb + frac_bits + 1;
    return ((pw > REG_W) ? pw : REG_W) + 1;
  endfunction

endpackage

// File: rtl/core/bdv_axis_dist.sv
// ----------------------------------------------------------------------------
// bdv_axis_dist
// Signed distance of a voxel position to the faces of one box axis.
// ----------------------------------------------------------------------------
module bdv_axis_dist
  import bdv_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic [IDX_W-1:0]                                 idx_i,
  input  logic signed [REG_W-1:0]                          lo_i,
  input  logic signed [REG_W-1:0]                          hi_i,
  output logic signed [dist_w(COORD_BITS, FRAC_BITS)-1:0]  dist_o
);

  localparam int unsigned CB  = (COORD_BITS < IDX_W) ? COORD_BITS : IDX_W;
  localparam int unsigned D_W = dist_w(COORD_BITS, FRAC_BITS);

  logic signed [D_W-1:0] pos;
  logic signed [D_W-1:0] lo;
  logic signed [D_W-1:0] hi;
  logic signed [D_W:0]   pos2;
  logic signed [D_W:0]   mid2;

  always_comb begin
    pos  = $signed(D_W'({idx_i[CB-1:0], {FRAC_BITS{1'b0}}}));
    lo   = D_W'(lo_i);
    hi   = D_W'(hi_i);
    pos2 = {pos, 1'b0};
    mid2 = (D_W+1)'(lo_i) + (D_W+1)'(hi_i);
    if (pos < lo) begin
      dist_o = pos - lo;
    end else if (pos > hi) begin
      dist_o = hi - pos;
    end else if (pos2 < mid2) begin
      dist_o = pos - lo;
    end else begin
      dist_o = hi - pos;
    end
  end

endmodule

// File: rtl/core/bdv_sqrt_cell.sv
// ----------------------------------------------------------------------------
// bdv_sqrt_cell
// One stage of the digit-by-digit square root: settles one root bit.
// ----------------------------------------------------------------------------
module bdv_sqrt_cell
  import bdv_pkg::*;
#(
  parameter int unsigned RAD_W  = 32,
  parameter int unsigned ROOT_W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bdv_side_t         side_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [ROOT_W+1:0] rem_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic              ready_i,
  output logic              ready_o,
  output bdv_side_t         side_o,
  output logic [RAD_W-1:0]  rad_o,
  output logic [ROOT_W+1:0] rem_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [ROOT_W+3:0] cand;
  logic [ROOT_W+3:0] trial;
  logic              take;
  logic [ROOT_W+1:0] rem_d;
  logic [ROOT_W-1:0] root_d;
  logic [RAD_W-1:0]  rad_d;

  assign ready_o = !side_o.valid || ready_i;

  always_comb begin
    cand   = {rem_i, rad_i[RAD_W-1 -: 2]};
    trial  = {2'b00, root_i, 2'b01};
    take   = (cand >= trial);
    rem_d  = take ? (ROOT_W+2)'(cand - trial) : cand[ROOT_W+1:0];
    root_d = {root_i[ROOT_W-2:0], take};
    rad_d  = {rad_i[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_o <= '0;
    end else if (ready_o) begin
      side_o <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      rad_o  <= rad_d;
      rem_o  <= rem_d;
      root_o <= root_d;
    end
  end

endmodule

// File: rtl/core/box_distance_voxelizer_core.sv
// ----------------------------------------------------------------------------
// box_distance_voxelizer_core
// Clamped signed distance of a voxel to an axis-aligned box.
// ----------------------------------------------------------------------------
// Takes one voxel per cycle, unless back-pressure from the output fills the
// pipeline, and returns one 8-bit value per voxel, in order. A voxel passes
// through five stages of axis distance, squaring, summing and two scalings by
// VALUE_MAX, then through the square-root chain, one cell per root bit, where
// ROOT_W = FRAC_BITS + 1 + clog2(VALUE_MAX + 1). The pipeline stalls only where
// it is full; bubbles are taken up. Bound registers are written through the cfg
// channel; the user must write them only while no voxel is in flight, as the
// block does not enforce it; index values beyond the six bounds are ignored.
// ----------------------------------------------------------------------------
module box_distance_voxelizer_core
  import bdv_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned FRAC_BITS  = 8,
  parameter int unsigned VALUE_MAX  = 127
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [IN_DATA_W-1:0] s_axis_tdata_i,  // x_index, y_index, z_index
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [VALUE_W-1:0]   m_axis_tdata_o   // voxel_value
);

  localparam int unsigned D_W    = dist_w(COORD_BITS, FRAC_BITS);
  localparam int unsigned MW     = FRAC_BITS + 2;
  localparam int unsigned SW     = 2 * MW;
  localparam int unsigned SLW    = 2 * FRAC_BITS + 2;
  localparam int unsigned VMB    = $clog2(VALUE_MAX + 1);
  localparam int unsigned M1W    = SLW + VMB;
  localparam int unsigned RAD_W  = SLW + 2 * VMB;
  localparam int unsigned ROOT_W = RAD_W / 2;

  localparam logic [MW-1:0]         LIM      = MW'(1) << (FRAC_BITS + 1);
  localparam logic [ROOT_W-1:0]     ONE      = ROOT_W'(1) << FRAC_BITS;
  localparam logic [VMB-1:0]        VM       = VMB'(VALUE_MAX);
  localparam logic signed [VMB:0]   VM_S     = (VMB+1)'(VALUE_MAX);
  localparam logic [ROOT_W:0]       ROOT_LIM = (ROOT_W+1)'(VALUE_MAX) << (FRAC_BITS + 1);

  // Configuration
  logic signed [REG_W-1:0] bound_q [2*NUM_AXES];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2 * NUM_AXES; i++) begin
        bound_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (bdv_reg_e'(cfg_index_i))
        REG_BOX_MIN_X: bound_q[0] <= cfg_data_i;
        REG_BOX_MAX_X: bound_q[1] <= cfg_data_i;
        REG_BOX_MIN_Y: bound_q[2] <= cfg_data_i;
        REG_BOX_MAX_Y: bound_q[3] <= cfg_data_i;
        REG_BOX_MIN_Z: bound_q[4] <= cfg_data_i;
        REG_BOX_MAX_Z: bound_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Flow control
  logic      en_a, en_b, en_c, en_d, en_e, en_o;
  logic      va_q, vb_q;
  bdv_side_t side_c_q, side_d_q, side_e_q;
  logic      out_valid_q;

  bdv_side_t         cell_side [ROOT_W+1];
  logic [RAD_W-1:0]  cell_rad  [ROOT_W+1];
  logic [ROOT_W+1:0] cell_rem  [ROOT_W+1];
  logic [ROOT_W-1:0] cell_root [ROOT_W+1];
  logic              cell_rdy  [ROOT_W+1];

  assign en_o            = !out_valid_q || m_axis_tready_i;
  assign cell_rdy[ROOT_W] = en_o;
  assign en_e            = !side_e_q.valid || cell_rdy[0];
  assign en_d            = !side_d_q.valid || en_e;
  assign en_c            = !side_c_q.valid || en_d;
  assign en_b            = !vb_q || en_c;
  assign en_a            = !va_q || en_b;
  assign s_axis_tready_o = en_a;

  // Stage A: axis distances
  logic signed [D_W-1:0] dist_d [NUM_AXES];
  logic signed [D_W-1:0] dist_q [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    bdv_axis_dist #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_axis (
      .idx_i  (s_axis_tdata_i[a*IDX_W +: IDX_W]),
      .lo_i   (bound_q[2*a]),
      .hi_i   (bound_q[2*a+1]),
      .dist_o (dist_d[a])
    );
  end

  // Stage B: clamp and square
  logic [D_W-1:0] mag      [NUM_AXES];
  logic [MW-1:0]  mag_c    [NUM_AXES];
  logic [SW-1:0]  sq_q     [NUM_AXES];
  logic [NUM_AXES-1:0] neg_q, pos_q;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      mag[a]   = (dist_q[a] < 0) ? D_W'(-dist_q[a]) : D_W'(dist_q[a]);
      mag_c[a] = (mag[a] > D_W'(LIM)) ? LIM : mag[a][MW-1:0];
    end
  end

  // Stage C: sum and saturation check
  logic [SW-1:0] sum_all, sum_neg, sum_sel;
  logic          all_pos;
  logic [SLW-1:0] s_lo_q;

  always_comb begin
    sum_all = '0;
    sum_neg = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      sum_all = sum_all + sq_q[a];
      sum_neg = sum_neg + (neg_q[a] ? sq_q[a] : SW'(0));
    end
    all_pos = &pos_q;
    sum_sel = all_pos ? sum_all : sum_neg;
  end

  // Stages D and E: scale by VALUE_MAX twice
  logic [M1W-1:0]   m1_q;
  logic [RAD_W-1:0] rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q     <= 1'b0;
      vb_q     <= 1'b0;
      side_c_q <= '0;
      side_d_q <= '0;
      side_e_q <= '0;
    end else begin
      if (en_a) va_q <= s_axis_tvalid_i;
      if (en_b) vb_q <= va_q;
      if (en_c) begin
        side_c_q.valid   <= vb_q;
        side_c_q.all_pos <= all_pos;
        side_c_q.sat     <= (sum_sel[SW-1 -: 2] != 2'b00);
      end
      if (en_d) side_d_q <= side_c_q;
      if (en_e) side_e_q <= side_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) dist_q <= dist_d;
    if (en_b) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        sq_q[a]  <= mag_c[a] * mag_c[a];
        neg_q[a] <= (dist_q[a] < 0);
        pos_q[a] <= (dist_q[a] > 0);
      end
    end
    if (en_c) s_lo_q <= sum_sel[SLW-1:0];
    if (en_d) m1_q   <= M1W'(s_lo_q * VM);
    if (en_e) rad_q  <= RAD_W'(m1_q * VM);
  end

  // Square-root cell chain
  assign cell_side[0] = side_e_q;
  assign cell_rad[0]  = rad_q;
  assign cell_rem[0]  = '0;
  assign cell_root[0] = '0;

  for (genvar c = 0; c < ROOT_W; c++) begin : g_cell
    bdv_sqrt_cell #(
      .RAD_W  (RAD_W),
      .ROOT_W (ROOT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .side_i  (cell_side[c]),
      .rad_i   (cell_rad[c]),
      .rem_i   (cell_rem[c]),
      .root_i  (cell_root[c]),
      .ready_i (cell_rdy[c+1]),
      .ready_o (cell_rdy[c]),
      .side_o  (cell_side[c+1]),
      .rad_o   (cell_rad[c+1]),
      .rem_o   (cell_rem[c+1]),
      .root_o  (cell_root[c+1])
    );
  end

  // Output: round and saturate
  bdv_side_t            last;
  logic [ROOT_W-1:0]    root;
  logic [ROOT_W:0]      q_up;
  logic [ROOT_W-1:0]    q_dn;
  logic signed [VMB:0]  value;
  logic [VALUE_W-1:0]   out_q;

  always_comb begin
    last = cell_side[ROOT_W];
    root = cell_root[ROOT_W];
    q_up = {1'b0, root} + {1'b0, ONE};
    q_dn = root - ONE;
    if (last.sat) begin
      value = last.all_pos ? VM_S : -VM_S;
    end else if (last.all_pos) begin
      value = $signed({1'b0, q_up[FRAC_BITS+VMB:FRAC_BITS+1]});
    end else if (root >= ONE) begin
      value = -$signed({1'b0, q_dn[ROOT_W-1:FRAC_BITS+1]});
    end else begin
      value = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_o) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) out_q <= VALUE_W'(value);
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // Assertions
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with output register empty");

  a_out_from_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(cell_side[ROOT_W].valid))
    else $error("result appeared without a transaction at the chain end");

  a_sat_pos_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_o && last.valid && last.sat && last.all_pos |=> m_axis_tdata_o == VALUE_W'(VM_S))
    else $error("saturated inside value is not VALUE_MAX");

  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last.valid && !last.sat |-> {1'b0, root} < ROOT_LIM)
    else $error("root exceeds VALUE_MAX range");

endmodule
